>>> rtl/cpir_pkg.sv
// ----------------------------------------------------------------------------
// cpir_pkg: shared types, widths and helpers
// Item layouts, pipeline sideband, contact codes and the scale/saturate helper
// used across the circle pair impulse resolve unit.
// ----------------------------------------------------------------------------
package cpir_pkg;

    localparam int FRAC_W   = 16;           // Q16.16 fraction bits
    localparam int VAL_W    = 32;           // signed Q16.16 words
    localparam int MAG_W    = 31;           // unsigned radius and inverse masses
    localparam int BNC_W    = 18;           // restitution sum, Q1.17
    localparam int IMS_W    = MAG_W + 1;    // inverse mass sum
    localparam int SQ_W     = 2 * VAL_W;    // squared distance
    localparam int ROOT_W   = SQ_W / 2;     // distance
    localparam int QUO_W    = FRAC_W + 1;   // normal and share quotients, at most 1.0
    localparam int DNUM_W   = VAL_W + FRAC_W;
    localparam int NRM_W    = QUO_W + 1;    // signed normal component
    localparam int PROD_W   = 55;           // widest signed product fed to scale_sat
    localparam int KB_W     = BNC_W + 1;    // 1 + e scaled by 2^17
    localparam int SQRT_LAT = ROOT_W;
    localparam int DIV_LAT  = QUO_W;
    localparam int TAIL_LAT = 9;

    // 1.0 + e is (RESTIT_BASE + bounce_total) / RESTIT_BASE
    localparam logic [KB_W-1:0] RESTIT_BASE = KB_W'(131072);

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SHIFT = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] offset_x;
        logic signed [VAL_W-1:0] offset_y;
        logic signed [VAL_W-1:0] rel_vel_x;
        logic signed [VAL_W-1:0] rel_vel_y;
        logic        [MAG_W-1:0] radius_total;
        logic        [MAG_W-1:0] inv_mass_a;
        logic        [MAG_W-1:0] inv_mass_b;
        logic        [BNC_W-1:0] bounce_total;
        logic                    static_a;
        logic                    static_b;
    } pair_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] a_shift_x;
        logic signed [VAL_W-1:0] a_shift_y;
        logic signed [VAL_W-1:0] b_shift_x;
        logic signed [VAL_W-1:0] b_shift_y;
        logic signed [VAL_W-1:0] a_dvel_x;
        logic signed [VAL_W-1:0] a_dvel_y;
        logic signed [VAL_W-1:0] b_dvel_x;
        logic signed [VAL_W-1:0] b_dvel_y;
        logic        [1:0]       contact_kind;
    } result_t;

    // sideband carried alongside the square root and the dividers
    typedef struct packed {
        logic                    kill;
        logic        [VAL_W-1:0] adx;
        logic        [VAL_W-1:0] ady;
        logic                    dx_neg;
        logic                    dy_neg;
        logic signed [VAL_W-1:0] vx;
        logic signed [VAL_W-1:0] vy;
        logic        [MAG_W-1:0] rad;
        logic        [MAG_W-1:0] ima;
        logic        [MAG_W-1:0] imb;
        logic        [IMS_W-1:0] ims;
        logic        [BNC_W-1:0] bounce;
        logic                    sa;
        logic                    sb;
        logic       [ROOT_W-1:0] root_len;
    } pipe_t;

    // p / 65536 truncated toward zero, optionally negated, saturated to 32 bits
    function automatic logic signed [VAL_W-1:0] scale_sat(
        input logic signed [PROD_W-1:0] p,
        input logic                     neg
    );
        logic signed [PROD_W-FRAC_W:0] q;
        logic signed [VAL_W-1:0]       r;
        q = {p[PROD_W-1], p[PROD_W-1:FRAC_W]};
        if (p[PROD_W-1] && (p[FRAC_W-1:0] != '0))
        begin
            q = q + (PROD_W-FRAC_W+1)'(1);
        end
        if (neg)
        begin
            q = -q;
        end
        if (q > $signed((PROD_W-FRAC_W+1)'(32'h7fff_ffff)))
        begin
            r = 32'sh7fff_ffff;
        end
        else if (q < -$signed((PROD_W-FRAC_W+1)'(33'h0_8000_0000)))
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = q[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/cpir_if.sv
// ----------------------------------------------------------------------------
// cpir_if: item channels
// Valid/ready channels for circle pairs in and resolved results out.
// ----------------------------------------------------------------------------
interface cpir_pair_if import cpir_pkg::*; ();
    logic  valid;
    logic  ready;
    pair_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cpir_result_if import cpir_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cpir_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// cpir_sqrt_pipe: pipelined integer square root
// One root bit per stage, floor of the square root of a 64 bit radicand.
// ----------------------------------------------------------------------------
module cpir_sqrt_pipe import cpir_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   radicand,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 3;

    logic [SQ_W-1:0]   val_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_stage
        logic [SQ_W-1:0]   val_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  r_try;
        logic [REM_W-1:0]  t_try;
        logic              ge;
        logic [SQ_W-1:0]   val_next;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (g == 0)
        begin : g_first
            assign val_in  = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign val_in  = val_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
        end

        // bring down two bits, try (root << 2) | 1
        always_comb
        begin
            r_try     = {rem_in[REM_W-3:0], val_in[SQ_W-1:SQ_W-2]};
            t_try     = {1'b0, root_in, 2'b01};
            ge        = (r_try >= t_try);
            rem_next  = ge ? (r_try - t_try) : r_try;
            root_next = {root_in[ROOT_W-2:0], ge};
            val_next  = {val_in[SQ_W-3:0], 2'b00};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg[g]  <= val_next;
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

>>> rtl/cpir_div_pipe.sv
// ----------------------------------------------------------------------------
// cpir_div_pipe: pipelined restoring divider
// One quotient bit per stage; the quotient must fit QUO_W bits.
// ----------------------------------------------------------------------------
module cpir_div_pipe import cpir_pkg::*;
#(
    parameter int NUM_W = DNUM_W,
    parameter int DEN_W = ROOT_W,
    parameter int QW    = QUO_W
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QW-1:0]    quo
);

    localparam int CW = ((NUM_W > DEN_W + QW - 1) ? NUM_W : DEN_W + QW - 1) + 1;

    logic [CW-1:0]    rem_reg [QW];
    logic [DEN_W-1:0] den_reg [QW];
    logic [QW-1:0]    quo_reg [QW];

    for (genvar g = 0; g < QW; g++)
    begin : g_stage
        logic [CW-1:0]    rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QW-1:0]    quo_in;
        logic [CW-1:0]    trial;
        logic             ge;
        logic [CW-1:0]    rem_next;
        logic [QW-1:0]    quo_next;

        if (g == 0)
        begin : g_first
            assign rem_in = CW'(num);
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
            assign quo_in = quo_reg[g-1];
        end

        always_comb
        begin
            trial    = CW'(den_in) << (QW - 1 - g);
            ge       = (rem_in >= trial);
            rem_next = ge ? (rem_in - trial) : rem_in;
            quo_next = {quo_in[QW-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next;
                den_reg[g] <= den_in;
                quo_reg[g] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

>>> rtl/cpir_tail_pipe.sv
// ----------------------------------------------------------------------------
// cpir_tail_pipe: correction and impulse stages
// From normal, shares and distance, form the position shifts, the reflected
// normal impulse and the per-body velocity changes, then select the result.
// ----------------------------------------------------------------------------
module cpir_tail_pipe import cpir_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  pipe_t            in_p,
    input  logic [QUO_W-1:0] nx_mag,
    input  logic [QUO_W-1:0] ny_mag,
    input  logic [QUO_W-1:0] ra,
    input  logic [QUO_W-1:0] rb,
    output logic             out_vld,
    output result_t          out_r
);

    typedef struct packed {
        logic                     kill;
        logic                     sa;
        logic                     sb;
        logic        [BNC_W-1:0]  bounce;
        logic signed [VAL_W-1:0]  vx;
        logic signed [VAL_W-1:0]  vy;
        logic signed [NRM_W-1:0]  nx;
        logic signed [NRM_W-1:0]  ny;
        logic        [QUO_W-1:0]  ra;
        logic        [QUO_W-1:0]  rb;
        logic        [MAG_W-1:0]  pen;
        logic        [MAG_W-1:0]  wa;
        logic        [MAG_W-1:0]  wb;
        logic signed [49:0]       px;
        logic signed [49:0]       py;
        logic signed [50:0]       s;
        logic signed [49:0]       pax;
        logic signed [49:0]       pay;
        logic signed [49:0]       pbx;
        logic signed [49:0]       pby;
        logic                     sep;
        logic signed [34:0]       van;
        logic        [KB_W-1:0]   kb;
        logic signed [VAL_W-1:0]  sh_ax;
        logic signed [VAL_W-1:0]  sh_ay;
        logic signed [VAL_W-1:0]  sh_bx;
        logic signed [VAL_W-1:0]  sh_by;
        logic signed [PROD_W-1:0] m;
        logic        [35:0]       jm;
        logic        [35:0]       ja;
        logic        [35:0]       jb;
        logic signed [PROD_W-1:0] dax;
        logic signed [PROD_W-1:0] day;
        logic signed [PROD_W-1:0] dbx;
        logic signed [PROD_W-1:0] dby;
    } tail_t;

    tail_t                st_reg  [TAIL_LAT];
    tail_t                st_next [TAIL_LAT];
    logic [TAIL_LAT-1:0]  vld_reg;
    result_t              res_next;

    logic [47:0]          pw_a;
    logic [47:0]          pw_b;
    logic [52:0]          pj_a;
    logic [52:0]          pj_b;
    logic signed [50:0]   s_adj;
    logic signed [PROD_W-1:0] m_neg;

    always_comb
    begin
        // P1: sign the normal, penetration depth
        st_next[0]        = '0;
        st_next[0].kill   = in_p.kill;
        st_next[0].sa     = in_p.sa;
        st_next[0].sb     = in_p.sb;
        st_next[0].bounce = in_p.bounce;
        st_next[0].vx     = in_p.vx;
        st_next[0].vy     = in_p.vy;
        st_next[0].nx     = in_p.dx_neg ? -$signed({1'b0, nx_mag}) : $signed({1'b0, nx_mag});
        st_next[0].ny     = in_p.dy_neg ? -$signed({1'b0, ny_mag}) : $signed({1'b0, ny_mag});
        st_next[0].ra     = ra;
        st_next[0].rb     = rb;
        st_next[0].pen    = in_p.rad - in_p.root_len[MAG_W-1:0];

        // P2: per-body depth share, normal velocity products
        st_next[1]    = st_reg[0];
        pw_a          = {17'b0, st_reg[0].pen} * {31'b0, st_reg[0].ra};
        pw_b          = {17'b0, st_reg[0].pen} * {31'b0, st_reg[0].rb};
        st_next[1].wa = pw_a[46:16];
        st_next[1].wb = pw_b[46:16];
        st_next[1].px = $signed(st_reg[0].vx) * $signed(st_reg[0].nx);
        st_next[1].py = $signed(st_reg[0].vy) * $signed(st_reg[0].ny);

        // P3: normal speed sum, shift products
        st_next[2]     = st_reg[1];
        st_next[2].s   = 51'(st_reg[1].px) + 51'(st_reg[1].py);
        st_next[2].pax = $signed(st_reg[1].nx) * $signed({1'b0, st_reg[1].wa});
        st_next[2].pay = $signed(st_reg[1].ny) * $signed({1'b0, st_reg[1].wa});
        st_next[2].pbx = $signed(st_reg[1].nx) * $signed({1'b0, st_reg[1].wb});
        st_next[2].pby = $signed(st_reg[1].ny) * $signed({1'b0, st_reg[1].wb});

        // P4: truncate normal speed, scale shifts
        st_next[3]       = st_reg[2];
        s_adj            = st_reg[2].s + (st_reg[2].s[50] ? 51'sd65535 : 51'sd0);
        st_next[3].sep   = (st_reg[2].s > 51'sd0);
        st_next[3].van   = s_adj[50:16];
        st_next[3].kb    = RESTIT_BASE + KB_W'(st_reg[2].bounce);
        st_next[3].sh_ax = scale_sat(PROD_W'(st_reg[2].pax), 1'b1);
        st_next[3].sh_ay = scale_sat(PROD_W'(st_reg[2].pay), 1'b1);
        st_next[3].sh_bx = scale_sat(PROD_W'(st_reg[2].pbx), 1'b0);
        st_next[3].sh_by = scale_sat(PROD_W'(st_reg[2].pby), 1'b0);

        // P5: apply 1 + e
        st_next[4]   = st_reg[3];
        st_next[4].m = $signed(st_reg[3].van) * $signed({1'b0, st_reg[3].kb});

        // P6: impulse magnitude, approach speed is never positive here
        st_next[5]    = st_reg[4];
        m_neg         = -st_reg[4].m;
        st_next[5].jm = m_neg[52:17];

        // P7: per-body impulse share
        st_next[6]    = st_reg[5];
        pj_a          = {17'b0, st_reg[5].jm} * {36'b0, st_reg[5].ra};
        pj_b          = {17'b0, st_reg[5].jm} * {36'b0, st_reg[5].rb};
        st_next[6].ja = pj_a[51:16];
        st_next[6].jb = pj_b[51:16];

        // P8: along the normal
        st_next[7]     = st_reg[6];
        st_next[7].dax = $signed(st_reg[6].nx) * $signed({1'b0, st_reg[6].ja});
        st_next[7].day = $signed(st_reg[6].ny) * $signed({1'b0, st_reg[6].ja});
        st_next[7].dbx = $signed(st_reg[6].nx) * $signed({1'b0, st_reg[6].jb});
        st_next[7].dby = $signed(st_reg[6].ny) * $signed({1'b0, st_reg[6].jb});

        // P9 keeps the products; the result is selected below
        st_next[8] = st_reg[7];
    end

    always_comb
    begin
        res_next = '0;
        if (!st_reg[8].kill)
        begin
            if (!st_reg[8].sa)
            begin
                res_next.a_shift_x = st_reg[8].sh_ax;
                res_next.a_shift_y = st_reg[8].sh_ay;
            end
            if (!st_reg[8].sb)
            begin
                res_next.b_shift_x = st_reg[8].sh_bx;
                res_next.b_shift_y = st_reg[8].sh_by;
            end
            if (st_reg[8].sep)
            begin
                res_next.contact_kind = KIND_SHIFT;
            end
            else
            begin
                res_next.contact_kind = KIND_FULL;
                if (!st_reg[8].sa)
                begin
                    res_next.a_dvel_x = scale_sat(st_reg[8].dax, 1'b1);
                    res_next.a_dvel_y = scale_sat(st_reg[8].day, 1'b1);
                end
                if (!st_reg[8].sb)
                begin
                    res_next.b_dvel_x = scale_sat(st_reg[8].dbx, 1'b0);
                    res_next.b_dvel_y = scale_sat(st_reg[8].dby, 1'b0);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < TAIL_LAT; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TAIL_LAT-2:0], in_vld};
        end
    end

    assign out_vld = vld_reg[TAIL_LAT-1];
    assign out_r   = res_next;

endmodule

>>> rtl/circle_pair_impulse_resolve_unit.sv
// ----------------------------------------------------------------------------
// circle_pair_impulse_resolve_unit: circle pair collision response
// Resolves one overlapping circle pair per item into position corrections and
// velocity changes for both bodies, Q16.16 throughout, results saturated.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake       item
//   -------   ---   -------------   ------------------------------------------
//   pair      in    valid / ready   offset, relative velocity, radii, masses
//   result    out   valid / ready   shifts, velocity changes, contact kind
//
// One item per cycle while the result side keeps taking items; the pipeline runs
// through the 32-stage square root followed by the 17-stage dividers.
// Reset clears only the valid bits; payload registers hold whatever they last had.
// The pipeline freezes as a whole only when its last stage is full and the
// output register still holds an item not taken; otherwise it keeps advancing.
//
module circle_pair_impulse_resolve_unit import cpir_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    cpir_pair_if.sink       pair,
    cpir_result_if.source   result
);

    // global advance
    logic en;

    // S0: captured item
    pair_t s0_reg;
    logic  s0_vld_reg;

    // S1: squares, magnitudes, inverse mass sum
    pipe_t            s1_next;
    pipe_t            s1_p_reg;
    logic             s1_vld_reg;
    logic signed [SQ_W-1:0] sqx_full;
    logic signed [SQ_W-1:0] sqy_full;
    logic [SQ_W-1:0]  s1_sqx_reg;
    logic [SQ_W-1:0]  s1_sqy_reg;
    logic [SQ_W-1:0]  s1_rad2_reg;
    logic [SQ_W-1:0]  rad2_next;

    // S2: squared distance and the cases that give no change
    pipe_t            s2_next;
    pipe_t            s2_p_reg;
    logic             s2_vld_reg;
    logic [SQ_W-1:0]  d2_next;
    logic [SQ_W-1:0]  s2_d2_reg;

    // square root sideband
    pipe_t               sq_line_reg [SQRT_LAT];
    logic [SQRT_LAT-1:0] sq_vld_reg;
    logic [ROOT_W-1:0]   root;
    pipe_t               dv_in;

    // divider sideband
    pipe_t               dv_line_reg [DIV_LAT];
    logic [DIV_LAT-1:0]  dv_vld_reg;
    logic [QUO_W-1:0]    nx_mag;
    logic [QUO_W-1:0]    ny_mag;
    logic [QUO_W-1:0]    ra;
    logic [QUO_W-1:0]    rb;

    // tail and output register
    logic    tail_vld;
    result_t tail_r;
    result_t out_reg;
    logic    out_vld_reg;
    logic    out_load;

    // Advance whenever the last tail stage is empty or its item can move on.
    assign out_load    = !out_vld_reg || result.ready;
    assign en          = !tail_vld || out_load;
    assign pair.ready  = en;

    // ---- S1 ----------------------------------------------------------------
    always_comb
    begin
        sqx_full = s0_reg.offset_x * s0_reg.offset_x;
        sqy_full = s0_reg.offset_y * s0_reg.offset_y;
        rad2_next = {33'b0, s0_reg.radius_total} * {33'b0, s0_reg.radius_total};

        s1_next        = '0;
        s1_next.adx    = s0_reg.offset_x[VAL_W-1] ? (~s0_reg.offset_x + 32'd1)
                                                  : s0_reg.offset_x;
        s1_next.ady    = s0_reg.offset_y[VAL_W-1] ? (~s0_reg.offset_y + 32'd1)
                                                  : s0_reg.offset_y;
        s1_next.dx_neg = s0_reg.offset_x[VAL_W-1];
        s1_next.dy_neg = s0_reg.offset_y[VAL_W-1];
        s1_next.vx     = s0_reg.rel_vel_x;
        s1_next.vy     = s0_reg.rel_vel_y;
        s1_next.rad    = s0_reg.radius_total;
        s1_next.ima    = s0_reg.inv_mass_a;
        s1_next.imb    = s0_reg.inv_mass_b;
        s1_next.ims    = {1'b0, s0_reg.inv_mass_a} + {1'b0, s0_reg.inv_mass_b};
        s1_next.bounce = s0_reg.bounce_total;
        s1_next.sa     = s0_reg.static_a;
        s1_next.sb     = s0_reg.static_b;
    end

    // ---- S2 ----------------------------------------------------------------
    // Drop to no change: both static, coincident centres, no overlap, or
    // both masses infinite.
    always_comb
    begin
        d2_next      = s1_sqx_reg + s1_sqy_reg;
        s2_next      = s1_p_reg;
        s2_next.kill = (s1_p_reg.sa && s1_p_reg.sb) || (d2_next == '0)
                       || (d2_next >= s1_rad2_reg) || (s1_p_reg.ims == '0);
    end

    // ---- payload registers -------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg      <= pair.data;
            s1_p_reg    <= s1_next;
            s1_sqx_reg  <= sqx_full;
            s1_sqy_reg  <= sqy_full;
            s1_rad2_reg <= rad2_next;
            s2_p_reg    <= s2_next;
            s2_d2_reg   <= d2_next;
            sq_line_reg[0] <= s2_p_reg;
            for (int i = 1; i < SQRT_LAT; i++)
            begin
                sq_line_reg[i] <= sq_line_reg[i-1];
            end
            dv_line_reg[0] <= dv_in;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                dv_line_reg[i] <= dv_line_reg[i-1];
            end
        end
    end

    // ---- valid bits --------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            sq_vld_reg <= '0;
            dv_vld_reg <= '0;
        end
        else if (en)
        begin
            s0_vld_reg <= pair.valid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            sq_vld_reg <= {sq_vld_reg[SQRT_LAT-2:0], s2_vld_reg};
            dv_vld_reg <= {dv_vld_reg[DIV_LAT-2:0], sq_vld_reg[SQRT_LAT-1]};
        end
    end

    // ---- distance ----------------------------------------------------------
    cpir_sqrt_pipe u_sqrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (s2_d2_reg),
        .root     (root)
    );

    always_comb
    begin
        dv_in          = sq_line_reg[SQRT_LAT-1];
        dv_in.root_len = root;
    end

    // ---- contact normal and mass shares -----------------------------------
    cpir_div_pipe #(.NUM_W(DNUM_W), .DEN_W(ROOT_W), .QW(QUO_W)) u_div_nx
    (
        .clk (clk),
        .en  (en),
        .num ({dv_in.adx, FRAC_W'(0)}),
        .den (root),
        .quo (nx_mag)
    );

    cpir_div_pipe #(.NUM_W(DNUM_W), .DEN_W(ROOT_W), .QW(QUO_W)) u_div_ny
    (
        .clk (clk),
        .en  (en),
        .num ({dv_in.ady, FRAC_W'(0)}),
        .den (root),
        .quo (ny_mag)
    );

    cpir_div_pipe #(.NUM_W(DNUM_W), .DEN_W(IMS_W), .QW(QUO_W)) u_div_ra
    (
        .clk (clk),
        .en  (en),
        .num ({1'b0, dv_in.ima, FRAC_W'(0)}),
        .den (dv_in.ims),
        .quo (ra)
    );

    cpir_div_pipe #(.NUM_W(DNUM_W), .DEN_W(IMS_W), .QW(QUO_W)) u_div_rb
    (
        .clk (clk),
        .en  (en),
        .num ({1'b0, dv_in.imb, FRAC_W'(0)}),
        .den (dv_in.ims),
        .quo (rb)
    );

    // ---- correction, impulse and selection --------------------------------
    cpir_tail_pipe u_tail
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (dv_vld_reg[DIV_LAT-1]),
        .in_p    (dv_line_reg[DIV_LAT-1]),
        .nx_mag  (nx_mag),
        .ny_mag  (ny_mag),
        .ra      (ra),
        .rb      (rb),
        .out_vld (tail_vld),
        .out_r   (tail_r)
    );

    // ---- output register ---------------------------------------------------
    // Hold the shown item until taken; take the next one from the tail.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= tail_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= tail_r;
        end
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_reg;

    // ---- assertions --------------------------------------------------------
    // input back-pressure only when the output holds an item not taken
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !pair.ready |-> (result.valid && !result.ready))
        else $error("input stalled without a blocked result");

    // no-change results carry all-zero fields
    a_none_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.contact_kind == KIND_NONE) |->
        (result.data.a_shift_x == '0 && result.data.a_shift_y == '0 &&
         result.data.b_shift_x == '0 && result.data.b_shift_y == '0 &&
         result.data.a_dvel_x == '0 && result.data.a_dvel_y == '0 &&
         result.data.b_dvel_x == '0 && result.data.b_dvel_y == '0))
        else $error("no-change result with non-zero fields");

    // separating pairs get no velocity change
    a_sep_no_dvel : assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.contact_kind == KIND_SHIFT) |->
        (result.data.a_dvel_x == '0 && result.data.a_dvel_y == '0 &&
         result.data.b_dvel_x == '0 && result.data.b_dvel_y == '0))
        else $error("separating result with velocity change");

    // a frozen pipeline keeps its last stage
    a_freeze : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(tail_vld))
        else $error("tail moved while frozen");

endmodule

>>> test/circle_pair_impulse_resolve_unit_tb.sv
// ----------------------------------------------------------------------------
// circle_pair_impulse_resolve_unit_tb: collision response self-checking bench
// Drives circle pairs through the pair channel and compares every resolved
// result, field by field, with an in-order prediction of shifts and impulses.
// ----------------------------------------------------------------------------
module circle_pair_impulse_resolve_unit_tb import cpir_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected results, kept in acceptance order, and the comparison of each
    // result item against the oldest one waiting.
    class contact_ledger;
        result_t pending[$];
        int      faults;

        function new();
            faults = 0;
        endfunction

        // Work out the response for an accepted pair and keep it in order.
        function void note_pair(pair_t p);
            pending.push_back(resolve_pair(p));
        endfunction

        // Compare a result item with the oldest expectation; drop it either way.
        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $realtime, got);
                faults++;
                return;
            end
            want = pending.pop_front();
            if (got.a_shift_x !== want.a_shift_x) report("a_shift_x", want.a_shift_x, got.a_shift_x);
            if (got.a_shift_y !== want.a_shift_y) report("a_shift_y", want.a_shift_y, got.a_shift_y);
            if (got.b_shift_x !== want.b_shift_x) report("b_shift_x", want.b_shift_x, got.b_shift_x);
            if (got.b_shift_y !== want.b_shift_y) report("b_shift_y", want.b_shift_y, got.b_shift_y);
            if (got.a_dvel_x !== want.a_dvel_x) report("a_dvel_x", want.a_dvel_x, got.a_dvel_x);
            if (got.a_dvel_y !== want.a_dvel_y) report("a_dvel_y", want.a_dvel_y, got.a_dvel_y);
            if (got.b_dvel_x !== want.b_dvel_x) report("b_dvel_x", want.b_dvel_x, got.b_dvel_x);
            if (got.b_dvel_y !== want.b_dvel_y) report("b_dvel_y", want.b_dvel_y, got.b_dvel_y);
            if (got.contact_kind !== want.contact_kind)
                report("contact_kind", 32'(want.contact_kind), 32'(got.contact_kind));
        endfunction

        function void report(string fld, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, fld, want, got);
            faults++;
        endfunction
    endclass

    // Truncating divide by 2^16, as the fixed-point scaling does.
    function automatic longint q16_scale(longint n, longint w);
        return (n * w) / 65536;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fff_ffff;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Bitwise integer square root of a 64 bit magnitude.
    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned rem, res, bitv;
        rem = v;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Position correction and impulse for one pair.
    function automatic result_t resolve_pair(pair_t p);
        result_t r;
        longint dx, dy, vx, vy, root_len, pen, nx, ny, ra, rb, wa, wb, s, van, jm, ja, jb;
        longint unsigned adx, ady, d2, rad, ims;
        r = '0;
        dx = longint'(p.offset_x);
        dy = longint'(p.offset_y);
        vx = longint'(p.rel_vel_x);
        vy = longint'(p.rel_vel_y);
        rad = {33'd0, p.radius_total};
        // both bodies pinned: nothing moves
        if (p.static_a && p.static_b) return r;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        d2 = adx * adx + ady * ady;
        // apart, or centres coincide so no normal exists
        if (d2 == 0 || d2 >= rad * rad) return r;
        ims = {33'd0, p.inv_mass_a} + {33'd0, p.inv_mass_b};
        if (ims == 0) return r;
        root_len = root64(d2);
        pen = longint'(rad) - root_len;
        nx = (dx * 65536) / root_len;
        ny = (dy * 65536) / root_len;
        ra = longint'(({33'd0, p.inv_mass_a} << 16) / ims);
        rb = longint'(({33'd0, p.inv_mass_b} << 16) / ims);
        wa = q16_scale(pen, ra);
        wb = q16_scale(pen, rb);
        if (!p.static_a)
        begin
            r.a_shift_x = clamp32(-q16_scale(nx, wa));
            r.a_shift_y = clamp32(-q16_scale(ny, wa));
        end
        if (!p.static_b)
        begin
            r.b_shift_x = clamp32(q16_scale(nx, wb));
            r.b_shift_y = clamp32(q16_scale(ny, wb));
        end
        s = vx * nx + vy * ny;
        // separating: correct position only
        if (s > 0)
        begin
            r.contact_kind = KIND_SHIFT;
            return r;
        end
        van = s / 65536;
        jm = -((van * (131072 + longint'(p.bounce_total))) / 131072);
        ja = q16_scale(jm, ra);
        jb = q16_scale(jm, rb);
        if (!p.static_a)
        begin
            r.a_dvel_x = clamp32(-q16_scale(nx, ja));
            r.a_dvel_y = clamp32(-q16_scale(ny, ja));
        end
        if (!p.static_b)
        begin
            r.b_dvel_x = clamp32(q16_scale(nx, jb));
            r.b_dvel_y = clamp32(q16_scale(ny, jb));
        end
        r.contact_kind = KIND_FULL;
        return r;
    endfunction

    logic clk;
    logic rst_n;

    cpir_pair_if   pair();
    cpir_result_if result();

    circle_pair_impulse_resolve_unit uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair.sink),
        .result (result.source)
    );

    contact_ledger ledger = new();

    // Idle odds in percent for each side; changed between phases.
    int  send_idle_pct;
    int  take_idle_pct;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Present one pair and hold it until taken. Valid stays high straight into
    // the next item when no idle cycle is drawn.
    task automatic send_pair(pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pair.valid <= 1'b0;
            @(posedge clk);
        end
        pair.valid <= 1'b1;
        pair.data  <= p;
        @(posedge clk);
        while (!pair.ready) @(posedge clk);
        ledger.note_pair(p);
    endtask

    // Mostly values that stay near the range where circles really overlap.
    function automatic logic [31:0] pick_word(int span);
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int span;
        span = ($urandom_range(7) == 0) ? 32'h3fff_ffff : (1 << $urandom_range(24, 8));
        p.offset_x  = pick_word(span);
        p.offset_y  = pick_word(span);
        p.rel_vel_x = pick_word(1 << $urandom_range(28, 4));
        p.rel_vel_y = pick_word(1 << $urandom_range(28, 4));
        // radius mostly large enough to overlap the chosen offsets
        case ($urandom_range(4))
            0:       p.radius_total = 31'($urandom());
            1:       p.radius_total = 31'h7fff_ffff;
            default: p.radius_total = 31'(span) * 31'($urandom_range(3, 1));
        endcase
        p.inv_mass_a   = ($urandom_range(5) == 0) ? 31'd0 : 31'($urandom());
        p.inv_mass_b   = ($urandom_range(5) == 0) ? 31'd0 : 31'($urandom());
        if ($urandom_range(2) == 0) p.inv_mass_a = 31'($urandom_range(1 << 18));
        p.bounce_total = 18'($urandom_range(131072));
        if ($urandom_range(15) == 0) p.bounce_total = 18'h3ffff;
        p.static_a     = ($urandom_range(4) == 0);
        p.static_b     = ($urandom_range(4) == 0);
        return p;
    endfunction

    function automatic pair_t make_pair(logic [31:0] dx, logic [31:0] dy, logic [31:0] vx,
                                        logic [31:0] vy, logic [30:0] rad, logic [30:0] ima,
                                        logic [30:0] imb, logic [17:0] bnc, bit sa, bit sb);
        pair_t p;
        p = {dx, dy, vx, vy, rad, ima, imb, bnc, sa, sb};
        return p;
    endfunction

    // Receiver: stall at random, check each item taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready) ledger.check_result(result.data);
            result.ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int n;
        rst_n = 1'b0;
        pair.valid = 1'b0;
        pair.data  = '0;
        send_idle_pct = 13;
        take_idle_pct = 54;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: head-on approach, separation, each degenerate case, extremes.
        send_pair(make_pair(32'h0001_0000, 0, 32'hffff_0000, 0, 31'h0002_0000,
                            31'h0001_0000, 31'h0001_0000, 18'h10000, 1'b0, 1'b0));
        send_pair(make_pair(32'h0001_0000, 0, 32'h0001_0000, 0, 31'h0002_0000,
                            31'h0001_0000, 31'h0001_0000, 18'h10000, 1'b0, 1'b0));
        send_pair(make_pair(32'h0001_0000, 0, 32'hffff_0000, 0, 31'h0002_0000,
                            31'h0001_0000, 31'h0001_0000, 18'h10000, 1'b1, 1'b1));
        send_pair(make_pair(32'h0003_0000, 0, 32'hffff_0000, 0, 31'h0002_0000,
                            31'h0001_0000, 31'h0001_0000, 18'h10000, 1'b0, 1'b0));
        send_pair(make_pair(32'h0002_0000, 0, 32'hffff_0000, 0, 31'h0002_0000,
                            31'h0001_0000, 31'h0001_0000, 18'h10000, 1'b0, 1'b0));
        send_pair(make_pair(0, 0, 32'hffff_0000, 0, 31'h0002_0000,
                            31'h0001_0000, 31'h0001_0000, 18'h10000, 1'b0, 1'b0));
        send_pair(make_pair(32'h0000_8000, 32'h0000_8000, 32'hfff0_0000, 0, 31'h0002_0000,
                            31'd0, 31'd0, 18'h10000, 1'b0, 1'b0));
        send_pair(make_pair(32'h0000_8000, 32'hffff_8000, 0, 32'h0010_0000, 31'h0002_0000,
                            31'h0001_0000, 31'd0, 18'h20000, 1'b1, 1'b0));
        send_pair(make_pair(32'hffff_8000, 32'h0000_4000, 32'h7fff_ffff, 32'h8000_0000,
                            31'h7fff_ffff, 31'd0, 31'h7fff_ffff, 18'h3ffff, 1'b0, 1'b1));
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                            31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 18'h00000, 1'b0, 1'b0));
        send_pair(make_pair(32'h0000_0001, 0, 32'h8000_0000, 32'h8000_0000,
                            31'h7fff_ffff, 31'h7fff_ffff, 31'h0000_0001, 18'h3ffff, 1'b0, 1'b0));
        send_pair(make_pair(0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                            31'h7fff_ffff, 31'h0000_0001, 31'h7fff_ffff, 18'h20000, 1'b0, 1'b0));
        send_pair(make_pair(32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h0,
                            31'h7fff_ffff, 31'h5555_5555, 31'h2aaa_aaaa, 18'h2aaaa, 1'b0, 1'b0));
        send_pair(make_pair(32'h0000_0001, 32'hffff_ffff, 32'hffff_ffff, 32'h1,
                            31'h0000_0002, 31'h0001_0000, 31'h0001_0000, 18'h10000, 1'b0, 1'b0));

        // Random: three idle phases across roughly 1450 items.
        for (n = 0; n < 1450; n++)
        begin
            if (n == 480)
            begin
                send_idle_pct = 54;
                take_idle_pct = 13;
            end
            if (n == 960)
            begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            send_pair(random_pair());
        end
        pair.valid <= 1'b0;

        // Drain every expectation, then watch for strays over the pipeline depth.
        while (ledger.pending.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        if (ledger.faults == 0)
            $display("circle_pair_impulse_resolve_unit_tb: done, clean");
        else
            $display("circle_pair_impulse_resolve_unit_tb: done, errors");
        $finish;
    end

    // Watchdog: ends the run with an error if the stimulus never finishes.
    initial
    begin
        #2ms;
        $display("circle_pair_impulse_resolve_unit_tb: done, errors");
        $finish;
    end

endmodule
